// ===== rtl/core/baof_pkg.sv =====
// Shared types and constants for the board average outlier flagger.
// No dependencies; imported by every module of the block.
package baof_pkg;

  // Table size and the widths that follow from it
  localparam int NUM_BOARDS = 512;
  localparam int ADDR_W     = (NUM_BOARDS > 1) ? $clog2(NUM_BOARDS) : 1;

  // Field widths
  localparam int REQ_W    = 2;
  localparam int BOARD_W  = 9;
  localparam int VALUE_W  = 16;
  localparam int SUM_W    = 32;
  localparam int COUNT_W  = 16;
  localparam int THRESH_W = 20;
  localparam int FRAC_W   = 4;
  localparam int PROD_W   = THRESH_W + COUNT_W;
  localparam int LHS_W    = SUM_W + FRAC_W;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_CLEAR    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ADD      = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLASSIFY = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ADC_AVG_MIN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOT_AVG_MIN = 1'd1;

  localparam logic [THRESH_W-1:0] THRESH_RESET = '1;

  // Input transaction
  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [BOARD_W-1:0] board_id;
    logic [VALUE_W-1:0] adc_value;
    logic [VALUE_W-1:0] tot_value;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic bad_adc;
    logic bad_tot;
  } result_t;

  // One table entry
  typedef struct packed {
    logic [SUM_W-1:0]   adc_sum;
    logic [SUM_W-1:0]   tot_sum;
    logic [COUNT_W-1:0] count;
  } entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture the incoming transaction
    logic clr_step;  // zero one table entry and advance the sweep
    logic rd;        // read the addressed entry
    logic wb;        // write back the accumulated entry
    logic mul;       // form threshold * count products
    logic cmp;       // compare and issue the result
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic op_add;    // captured transaction is an add
    logic clr_last;  // sweep is at the final entry
  } dp_status_t;

endpackage

// ===== rtl/core/baof_ctrl.sv =====
// Controller state machine for the board average outlier flagger.
// Depends on baof_pkg; drives baof_datapath through ctrl_cmd_t.
module baof_ctrl
  import baof_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [REQ_W-1:0] req_type,
  input  dp_status_t       status,
  output ctrl_cmd_t        cmd,
  output logic             busy
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CLEAR = 6'b000010,
    S_READ  = 6'b000100,
    S_WRITE = 6'b001000,
    S_MUL   = 6'b010000,
    S_CMP   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  // State register; reset starts a clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          case (req_type)
            REQ_CLEAR:    state_next = S_CLEAR;
            REQ_ADD:      state_next = S_READ;
            REQ_CLASSIFY: state_next = S_READ;
            default:      state_next = S_IDLE;  // unused code: no-op
          endcase
        end
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = status.op_add ? S_WRITE : S_MUL;
      end
      S_WRITE: begin
        cmd.wb     = 1'b1;
        state_next = S_IDLE;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        cmd.cmp    = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/baof_datapath.sv =====
// Datapath for the board average outlier flagger: board table, saturating
// accumulate, threshold products and compare. Depends on baof_pkg.
module baof_datapath
  import baof_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  in_item_t             item,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [THRESH_W-1:0]  cfg_data,
  input  ctrl_cmd_t            cmd,
  output dp_status_t           status,
  output result_t              result,
  output logic                 done
);

  // Threshold registers
  logic [THRESH_W-1:0] adc_avg_min;
  logic [THRESH_W-1:0] tot_avg_min;

  // Captured transaction
  logic               op_add;
  logic               board_ok;
  logic [ADDR_W-1:0]  addr;
  logic [VALUE_W-1:0] adc_val;
  logic [VALUE_W-1:0] tot_val;

  // Table and its read port
  entry_t             table_mem [NUM_BOARDS];
  entry_t             rd_data;
  logic [ADDR_W-1:0]  clr_addr;

  // Accumulate path
  logic [SUM_W:0]     adc_add;
  logic [SUM_W:0]     tot_add;
  entry_t             acc_entry;

  // Write port
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  entry_t             mem_wdata;

  // Compare path
  logic [PROD_W-1:0]  adc_prod;
  logic [PROD_W-1:0]  tot_prod;
  logic [LHS_W-1:0]   adc_lhs;
  logic [LHS_W-1:0]   tot_lhs;
  logic               cnt_nz;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      adc_avg_min <= THRESH_RESET;
      tot_avg_min <= THRESH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ADC_AVG_MIN: adc_avg_min <= cfg_data;
        CFG_TOT_AVG_MIN: tot_avg_min <= cfg_data;
        default: ;
      endcase
    end
  end

  // Transaction capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_add   <= (item.req_type == REQ_ADD);
      board_ok <= (32'(item.board_id) < 32'(NUM_BOARDS));
      addr     <= ADDR_W'(item.board_id);
      adc_val  <= item.adc_value;
      tot_val  <= item.tot_value;
    end
  end

  // Clearing sweep address; wraps to zero after the final entry
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      if (status.clr_last) begin
        clr_addr <= '0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  assign status.op_add   = op_add;
  assign status.clr_last = (32'(clr_addr) == 32'(NUM_BOARDS - 1));

  // Saturating accumulate of the entry read back
  always_comb begin
    adc_add = {1'b0, rd_data.adc_sum} + (SUM_W + 1)'(adc_val);
    tot_add = {1'b0, rd_data.tot_sum} + (SUM_W + 1)'(tot_val);
    acc_entry.adc_sum = adc_add[SUM_W] ? '1 : adc_add[SUM_W-1:0];
    acc_entry.tot_sum = tot_add[SUM_W] ? '1 : tot_add[SUM_W-1:0];
    acc_entry.count   = (&rd_data.count) ? rd_data.count : rd_data.count + 1'b1;
  end

  // Write port selection: sweep zeroes, add writes back in-range boards
  always_comb begin
    if (cmd.clr_step) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = cmd.wb && board_ok;
      mem_waddr = addr;
      mem_wdata = acc_entry;
    end
  end

  // Board table
  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data <= table_mem[addr];
    end
  end

  // Threshold * count products, sums scaled by 16
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      adc_prod <= PROD_W'(adc_avg_min) * PROD_W'(rd_data.count);
      tot_prod <= PROD_W'(tot_avg_min) * PROD_W'(rd_data.count);
      adc_lhs  <= {rd_data.adc_sum, {FRAC_W{1'b0}}};
      tot_lhs  <= {rd_data.tot_sum, {FRAC_W{1'b0}}};
      cnt_nz   <= |rd_data.count;
    end
  end

  // Compare and result register; empty or out-of-range boards flag nothing
  always_ff @(posedge clk) begin
    if (cmd.cmp) begin
      result.bad_adc <= board_ok && cnt_nz && (LHS_W'(adc_lhs) > LHS_W'(adc_prod));
      result.bad_tot <= board_ok && cnt_nz && (LHS_W'(tot_lhs) > LHS_W'(tot_prod));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.cmp;
    end
  end

endmodule

// ===== rtl/core/board_average_outlier_flagger.sv =====
// Top level of the board average outlier flagger.
// Depends on baof_pkg, baof_ctrl and baof_datapath.
//
// A transaction is taken when start is high and busy is low; one is in
// flight at a time. An add holds busy through the table read and then the
// saturating write-back. A classify holds busy through read, multiply and
// compare; done then strobes for one cycle with the flags on result, and a
// new transaction may be accepted in that same cycle. The receiver cannot
// stall, so result must be captured while done is high. A clear walks the
// board table one entry per cycle, holding busy until all NUM_BOARDS (512)
// entries are zeroed; the same sweep runs after reset. Request code 3 is
// accepted and dropped without leaving idle. Thresholds are written through
// cfg_write/cfg_index/cfg_data; the user must do so only while the block is
// idle, as the block itself does not enforce it.
module board_average_outlier_flagger
  import baof_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             item,
  output logic                 done,
  output result_t              result,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [THRESH_W-1:0]  cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer
  baof_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (item.req_type),
    .status   (status),
    .cmd      (cmd),
    .busy     (busy)
  );

  // Table and arithmetic
  baof_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .result    (result),
    .done      (done)
  );

endmodule
